[sv/srrs_pkg.sv]
`default_nettype none

package srrs_pkg;

    // Default sizes of the thread and semaphore tables
    localparam int DEF_MAX_THREADS = 16;
    localparam int DEF_NUM_SEMS    = 8;

    // Fixed widths of the port fields
    localparam int CMD_W      = 2;
    localparam int SEM_IDX_W  = 3;
    localparam int STATUS_W   = 3;
    localparam int THREAD_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int TC_W       = 5;
    localparam int SEM_INIT_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THREAD_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEM_INIT     = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_DOWN = 2'd1,
        CMD_UP   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE       = 3'd0,
        STS_BLOCKED    = 3'd1,
        STS_LOST_UP    = 3'd2,
        STS_NO_READY   = 3'd3,
        STS_QUEUE_FULL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_SEARCH,
        ST_WAKE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [SEM_IDX_W-1:0] sem_index;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [THREAD_W-1:0] running_thread;
        logic                switched;
        logic                woke;
        logic [THREAD_W-1:0] woken_thread;
    } t_out;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    latch;
        logic    take_val;
        logic    set_val;
        logic    enqueue;
        logic    mod_start;
        logic    search;
        logic    wake;
        logic    status_we;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             sem_ok;
        logic             sem_val;
        logic             fifo_full;
        logic             fifo_empty;
        logic             need_mod;
        logic             mod_busy;
        logic             found;
    } t_dp_stat;

endpackage

`default_nettype wire

[sv/srrs_dp.sv]
`default_nettype none

module srrs_dp #(
    parameter int MAX_THREADS = srrs_pkg::DEF_MAX_THREADS,
    parameter int NUM_SEMS    = srrs_pkg::DEF_NUM_SEMS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  srrs_pkg::t_in                         i_in,
    input  wire                                   i_cfg_we,
    input  wire  [srrs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [srrs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  srrs_pkg::t_dp_cmd                     i_cmd,
    output srrs_pkg::t_dp_stat                    o_stat,
    output srrs_pkg::t_out                        o_res
);
    import srrs_pkg::*;

    localparam int TW        = $clog2(MAX_THREADS);
    localparam int NW        = TW + 1;
    localparam int CW        = $clog2(MAX_THREADS + 1);
    localparam int SW        = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int MEM_DEPTH = NUM_SEMS * (1 << TW);
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int MCW       = $clog2(NW + 1);
    localparam int INIT_SEMS = (NUM_SEMS < SEM_INIT_W) ? NUM_SEMS : SEM_INIT_W;

    // Configuration and scheduler state
    logic [TC_W-1:0]        r_thread_count;
    logic [CMD_W-1:0]       r_cmd;
    logic [SEM_IDX_W-1:0]   r_sem;
    logic [TW-1:0]          r_cur;
    logic [MAX_THREADS-1:0] r_ready;
    logic [NUM_SEMS-1:0]    r_sem_val;
    logic [TW-1:0]          r_head [NUM_SEMS];
    logic [CW-1:0]          r_cnt  [NUM_SEMS];

    // Wait queues of all semaphores, one row of MAX_THREADS slots each
    logic [TW-1:0]          r_mem [MEM_DEPTH];
    logic [TW-1:0]          r_rd_data;

    // Remainder unit
    logic [NW-1:0]          r_mod_rem;
    logic [NW-1:0]          r_mod_val;
    logic [MCW-1:0]         r_mod_cnt;

    // Result fields
    t_status                r_status;
    logic                   r_switched;
    logic                   r_woke;
    logic [TW-1:0]          r_woken;

    logic [NW-1:0]          n_eff;
    logic [NW-1:0]          cur1;
    logic                   need_mod;
    logic [NW-1:0]          start;
    logic [SW-1:0]          sel;
    logic                   sem_ok;
    logic [CW-1:0]          cur_cnt;
    logic [TW-1:0]          cur_head;
    logic [NW-1:0]          pos_sum;
    logic [TW-1:0]          pos;
    logic [TW-1:0]          head_next;
    logic [AW-1:0]          wr_addr;
    logic [AW-1:0]          rd_addr;
    logic [NW:0]            rem_sh;
    logic [NW:0]            rem_sub;
    logic                   rem_ge;
    logic                   found;
    logic [TW-1:0]          next_thread;

    // Clamp the thread count to 1..MAX_THREADS
    always_comb begin
        if (r_thread_count == '0) begin
            n_eff = NW'(1);
        end else if (32'(r_thread_count) > 32'(MAX_THREADS)) begin
            n_eff = NW'(MAX_THREADS);
        end else begin
            n_eff = NW'(r_thread_count);
        end
    end

    // Search starts one past the current thread; wrap through the remainder unit
    // only when the current thread lies outside the active slots
    assign cur1     = NW'(r_cur) + NW'(1);
    assign need_mod = cur1 > n_eff;
    assign start    = need_mod ? r_mod_rem : cur1;

    // Selected semaphore
    assign sel      = SW'(r_sem);
    assign sem_ok   = 32'(r_sem) < 32'(NUM_SEMS);
    assign cur_cnt  = r_cnt[sel];
    assign cur_head = r_head[sel];

    // Tail slot and next head, wrapping at MAX_THREADS
    assign pos_sum   = NW'(cur_head) + NW'(cur_cnt);
    assign pos       = (pos_sum >= NW'(MAX_THREADS)) ? TW'(pos_sum - NW'(MAX_THREADS))
                                                     : TW'(pos_sum);
    assign head_next = ((NW'(cur_head) + NW'(1)) == NW'(MAX_THREADS)) ? '0
                                                                      : TW'(cur_head + 1'b1);
    assign wr_addr   = AW'({sel, pos});
    assign rd_addr   = AW'({sel, cur_head});

    // One restoring remainder step
    assign rem_sh  = {r_mod_rem, r_mod_val[NW-1]};
    assign rem_ge  = rem_sh >= (NW+1)'(n_eff);
    assign rem_sub = rem_sh - (NW+1)'(n_eff);

    // Find the first ready thread from the start slot, else the lowest one
    always_comb begin
        logic          cand;
        logic          hit_hi;
        logic [TW-1:0] idx_hi;
        logic          hit_any;
        logic [TW-1:0] idx_any;
        hit_hi  = 1'b0;
        idx_hi  = '0;
        hit_any = 1'b0;
        idx_any = '0;
        for (int p = MAX_THREADS - 1; p >= 0; p--) begin
            cand = r_ready[p] && (NW'(p) < n_eff) && (TW'(p) != r_cur);
            if (cand) begin
                hit_any = 1'b1;
                idx_any = TW'(p);
                if (NW'(p) >= start) begin
                    hit_hi = 1'b1;
                    idx_hi = TW'(p);
                end
            end
        end
        found       = hit_any;
        next_thread = hit_hi ? idx_hi : idx_any;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thread_count <= TC_W'(16);
        end else if (i_cfg_we && i_cfg_index == CFG_THREAD_COUNT) begin
            r_thread_count <= i_cfg_data[TC_W-1:0];
        end
    end

    // Semaphore values: reload from config, take on down, set on up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sem_val <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_SEM_INIT) begin
                for (int s = 0; s < INIT_SEMS; s++) begin
                    r_sem_val[s] <= i_cfg_data[s];
                end
            end
            if (i_cmd.take_val) begin
                r_sem_val[sel] <= 1'b0;
            end
            if (i_cmd.set_val) begin
                r_sem_val[sel] <= 1'b1;
            end
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SEMS; s++) begin
                r_head[s] <= '0;
                r_cnt[s]  <= '0;
            end
        end else if (i_cmd.enqueue) begin
            r_cnt[sel] <= cur_cnt + 1'b1;
        end else if (i_cmd.wake) begin
            r_cnt[sel]  <= cur_cnt - 1'b1;
            r_head[sel] <= head_next;
        end
    end

    // Current thread and ready marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_ready <= '1;
        end else begin
            if (i_cmd.enqueue) begin
                r_ready[r_cur] <= 1'b0;
            end
            if (i_cmd.wake) begin
                r_ready[r_rd_data] <= 1'b1;
            end
            if (i_cmd.search && found) begin
                r_cur <= next_thread;
            end
        end
    end

    // Queue memory: write the caller at the tail, read the head every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.enqueue) begin
            r_mem[wr_addr] <= r_cur;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Remainder step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_start) begin
            r_mod_cnt <= MCW'(NW);
        end else if (r_mod_cnt != '0) begin
            r_mod_cnt <= r_mod_cnt - 1'b1;
        end
    end

    // Remainder data path, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_mod_rem <= '0;
            r_mod_val <= cur1;
        end else if (r_mod_cnt != '0) begin
            r_mod_rem <= rem_ge ? NW'(rem_sub) : NW'(rem_sh);
            r_mod_val <= {r_mod_val[NW-2:0], 1'b0};
        end
    end

    // Latch the item and build the result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd      <= i_in.cmd;
            r_sem      <= i_in.sem_index;
            r_status   <= STS_DONE;
            r_switched <= 1'b0;
            r_woke     <= 1'b0;
            r_woken    <= '0;
        end else begin
            if (i_cmd.status_we) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.search && found) begin
                r_switched <= 1'b1;
            end
            if (i_cmd.wake) begin
                r_woke  <= 1'b1;
                r_woken <= r_rd_data;
            end
        end
    end

    assign o_stat.cmd        = r_cmd;
    assign o_stat.sem_ok     = sem_ok;
    assign o_stat.sem_val    = r_sem_val[sel];
    assign o_stat.fifo_full  = cur_cnt == CW'(MAX_THREADS);
    assign o_stat.fifo_empty = cur_cnt == '0;
    assign o_stat.need_mod   = need_mod;
    assign o_stat.mod_busy   = r_mod_cnt != '0;
    assign o_stat.found      = found;

    assign o_res.status         = r_status;
    assign o_res.running_thread = THREAD_W'(r_cur);
    assign o_res.switched       = r_switched;
    assign o_res.woke           = r_woke;
    assign o_res.woken_thread   = THREAD_W'(r_woken);

endmodule

`default_nettype wire

[sv/srrs_ctrl.sv]
`default_nettype none

module srrs_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire                 i_out_free,
    input  srrs_pkg::t_dp_stat  i_stat,
    output srrs_pkg::t_dp_cmd   o_cmd,
    output logic                o_load_out
);
    import srrs_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_load_out      = 1'b0;
        o_cmd.latch     = 1'b0;
        o_cmd.take_val  = 1'b0;
        o_cmd.set_val   = 1'b0;
        o_cmd.enqueue   = 1'b0;
        o_cmd.mod_start = 1'b0;
        o_cmd.search    = 1'b0;
        o_cmd.wake      = 1'b0;
        o_cmd.status_we = 1'b0;
        o_cmd.status    = STS_DONE;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DECODE;
                end
            end

            ST_DECODE: begin
                n_state = ST_FINISH;
                unique case (i_stat.cmd)
                    CMD_TICK: begin
                        o_cmd.mod_start = i_stat.need_mod;
                        n_state         = i_stat.need_mod ? ST_MOD : ST_SEARCH;
                    end
                    CMD_DOWN: begin
                        if (i_stat.sem_ok) begin
                            if (i_stat.sem_val) begin
                                o_cmd.take_val = 1'b1;
                            end else if (i_stat.fifo_full) begin
                                o_cmd.status_we = 1'b1;
                                o_cmd.status    = STS_QUEUE_FULL;
                            end else begin
                                // queue and block the caller, then reschedule
                                o_cmd.enqueue   = 1'b1;
                                o_cmd.mod_start = i_stat.need_mod;
                                n_state         = i_stat.need_mod ? ST_MOD : ST_SEARCH;
                            end
                        end
                    end
                    CMD_UP: begin
                        if (i_stat.sem_ok) begin
                            if (i_stat.sem_val) begin
                                o_cmd.status_we = 1'b1;
                                o_cmd.status    = STS_LOST_UP;
                            end else if (i_stat.fifo_empty) begin
                                o_cmd.set_val = 1'b1;
                            end else begin
                                n_state = ST_WAKE;
                            end
                        end
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end

            ST_MOD: begin
                if (!i_stat.mod_busy) begin
                    n_state = ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                o_cmd.search    = 1'b1;
                o_cmd.status_we = 1'b1;
                if (!i_stat.found) begin
                    o_cmd.status = STS_NO_READY;
                end else if (i_stat.cmd == CMD_DOWN) begin
                    o_cmd.status = STS_BLOCKED;
                end else begin
                    o_cmd.status = STS_DONE;
                end
                n_state = ST_FINISH;
            end

            ST_WAKE: begin
                o_cmd.wake = 1'b1;
                n_state    = ST_FINISH;
            end

            ST_FINISH: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/semaphore_round_robin_scheduler_unit.sv]
`default_nettype none

// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_in   (cmd, sem_index)
// output    out        o_out_valid / i_out_ready   o_out  (status, running_thread,
//                                                         switched, woke, woken_thread)
// config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// One item at a time: each passes IDLE, DECODE and FINISH; a tick or a blocking
// down adds SEARCH, after MOD in the remainder unit when the current thread sits
// at or above the thread count. The round-robin search checks all slots at once;
// a waking up adds WAKE, as the queue memory read is registered.
// A new item is taken while the previous result still waits in the output
// register; the block stalls in its last step until that register is free.
// Reset (synchronous, active low) gives thread 0 running, all threads ready,
// all semaphores 0 with empty queues, and a thread count of 16.

module semaphore_round_robin_scheduler_unit #(
    parameter int MAX_THREADS = srrs_pkg::DEF_MAX_THREADS,
    parameter int NUM_SEMS    = srrs_pkg::DEF_NUM_SEMS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  srrs_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output srrs_pkg::t_out                     o_out,
    input  wire                                i_cfg_we,
    input  wire  [srrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [srrs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import srrs_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_out     dp_res;
    logic     load_out;
    logic     out_free;
    logic     r_out_valid;
    t_out     r_out;

    // Output register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_out_ready;

    srrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_load_out (load_out)
    );

    srrs_dp #(
        .MAX_THREADS (MAX_THREADS),
        .NUM_SEMS    (NUM_SEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_res       (dp_res)
    );

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= dp_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
